### rtl/core/velocity_pid_with_windup_reset_core_macros.svh
// Assertion macros shared by the velocity PID core.
// Stands alone; included by files that carry concurrent assertions.
`ifndef VELOCITY_PID_WITH_WINDUP_RESET_CORE_MACROS_SVH
`define VELOCITY_PID_WITH_WINDUP_RESET_CORE_MACROS_SVH

// Checked at every rising edge outside reset.
`define VPID_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vpid assertion failed");

// Checked at every rising edge, reset included.
`define VPID_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vpid assertion failed");

`endif

### rtl/core/vpid_pkg.sv
// Shared widths, constants, register codes and the stage-one word type
// for the velocity PID core. Depends on nothing.
`timescale 1ns / 1ps

package vpid_pkg;

    localparam int VEL_W   = 16;   // Q2.14 velocity
    localparam int ERR_W   = 17;   // target minus measured
    localparam int DER_W   = 18;   // error minus previous error
    localparam int SUM_W   = 32;   // saturating integral
    localparam int GAIN_W  = 24;   // unsigned Q8.16
    localparam int LIM_W   = 17;
    localparam int MV_W    = 15;
    localparam int CFG_W   = 24;
    localparam int PRODP_W = GAIN_W + 1 + ERR_W;
    localparam int PRODI_W = GAIN_W + 1 + SUM_W;
    localparam int PRODD_W = GAIN_W + 1 + DER_W;
    localparam int ACC_W   = PRODI_W + 1;
    localparam int FRAC_SH = 16;

    localparam logic signed [VEL_W-1:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [VEL_W-1:0] M_ONE_Q14 = -16'sd16384;
    localparam logic signed [LIM_W-1:0] LIMIT_RST = 17'sd65535;
    localparam int FULL_MV = 12000;
    localparam int MV_SH   = 14;

    typedef enum logic [2:0] {
        CFG_TARGET = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_LIMIT  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] isum;
        logic signed [DER_W-1:0] deriv;
        logic                    tzero;
    } t_err_word;

endpackage

### rtl/core/vpid_err.sv
// Error stage: clamps the target, forms the error, keeps the saturating
// integral with its clearing rules and the previous error. Uses vpid_pkg.
`timescale 1ns / 1ps

module vpid_err (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic signed [vpid_pkg::VEL_W-1:0]     i_meas,
    input  logic signed [vpid_pkg::VEL_W-1:0]     i_target,
    input  logic signed [vpid_pkg::LIM_W-1:0]     i_err_limit,
    output vpid_pkg::t_err_word                   o_word
);

    logic signed [vpid_pkg::SUM_W-1:0] r_sum, n_sum;
    logic signed [vpid_pkg::ERR_W-1:0] r_last;
    vpid_pkg::t_err_word               r_word, n_word;

    logic signed [vpid_pkg::VEL_W-1:0] tgt;
    logic signed [vpid_pkg::ERR_W-1:0] meas_x, tgt_x, err;
    logic        [vpid_pkg::ERR_W-1:0] abs_meas, abs_tgt;
    logic signed [vpid_pkg::SUM_W:0]   sum_wide;
    logic signed [vpid_pkg::SUM_W-1:0] sum_sat;
    logic                              clear;

    always_comb begin
        if (i_target > vpid_pkg::ONE_Q14) begin
            tgt = vpid_pkg::ONE_Q14;
        end else if (i_target < vpid_pkg::M_ONE_Q14) begin
            tgt = vpid_pkg::M_ONE_Q14;
        end else begin
            tgt = i_target;
        end
        meas_x   = vpid_pkg::ERR_W'(i_meas);
        tgt_x    = vpid_pkg::ERR_W'(tgt);
        err      = tgt_x - meas_x;
        abs_meas = meas_x[vpid_pkg::ERR_W-1] ? -meas_x : meas_x;
        abs_tgt  = tgt_x[vpid_pkg::ERR_W-1] ? -tgt_x : tgt_x;

        sum_wide = (vpid_pkg::SUM_W+1)'(r_sum) + (vpid_pkg::SUM_W+1)'(err);
        // A carry into the top bit means the 32-bit range was left.
        if (sum_wide[vpid_pkg::SUM_W] != sum_wide[vpid_pkg::SUM_W-1]) begin
            sum_sat = sum_wide[vpid_pkg::SUM_W]
                    ? {1'b1, {(vpid_pkg::SUM_W-1){1'b0}}}
                    : {1'b0, {(vpid_pkg::SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[vpid_pkg::SUM_W-1:0];
        end

        clear = (err == '0) || (abs_meas > abs_tgt) || (err > i_err_limit);
        n_sum = clear ? '0 : sum_sat;

        n_word.err   = err;
        n_word.isum  = n_sum;
        n_word.deriv = vpid_pkg::DER_W'(err) - vpid_pkg::DER_W'(r_last);
        n_word.tzero = (tgt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (i_load) begin
            r_sum  <= n_sum;
            r_last <= err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### rtl/core/vpid_mac.sv
// Gain stage: three registered gain products, then their sum, the Q.14
// rounding shift, the clamp to plus or minus one and zero-target forcing.
// Uses vpid_pkg.
`timescale 1ns / 1ps

module vpid_mac (
    input  logic                                  i_clk,
    input  logic                                  i_load_prod,
    input  logic                                  i_load_drive,
    input  vpid_pkg::t_err_word                   i_word,
    input  logic [vpid_pkg::GAIN_W-1:0]           i_kp,
    input  logic [vpid_pkg::GAIN_W-1:0]           i_ki,
    input  logic [vpid_pkg::GAIN_W-1:0]           i_kd,
    output logic signed [vpid_pkg::VEL_W-1:0]     o_drive
);

    localparam int FRAC_SH_L = vpid_pkg::FRAC_SH;

    logic signed [vpid_pkg::PRODP_W-1:0] r_prod_p, n_prod_p;
    logic signed [vpid_pkg::PRODI_W-1:0] r_prod_i, n_prod_i;
    logic signed [vpid_pkg::PRODD_W-1:0] r_prod_d, n_prod_d;
    logic                                r_tzero;
    logic signed [vpid_pkg::VEL_W-1:0]   r_drive, n_drive;

    logic signed [vpid_pkg::GAIN_W:0]            kp_s, ki_s, kd_s;
    logic signed [vpid_pkg::ACC_W-1:0]           acc;
    logic signed [vpid_pkg::ACC_W-FRAC_SH_L-1:0] scaled;

    always_comb begin
        kp_s     = {1'b0, i_kp};
        ki_s     = {1'b0, i_ki};
        kd_s     = {1'b0, i_kd};
        n_prod_p = vpid_pkg::PRODP_W'(kp_s) * vpid_pkg::PRODP_W'(i_word.err);
        n_prod_i = vpid_pkg::PRODI_W'(ki_s) * vpid_pkg::PRODI_W'(i_word.isum);
        n_prod_d = vpid_pkg::PRODD_W'(kd_s) * vpid_pkg::PRODD_W'(i_word.deriv);
    end

    always_comb begin
        acc = vpid_pkg::ACC_W'(r_prod_p) + vpid_pkg::ACC_W'(r_prod_i)
            + vpid_pkg::ACC_W'(r_prod_d);
        // Arithmetic shift rounds toward minus infinity.
        scaled = acc[vpid_pkg::ACC_W-1:FRAC_SH_L];
        if (r_tzero) begin
            n_drive = '0;
        end else if (scaled > (vpid_pkg::ACC_W-FRAC_SH_L)'(vpid_pkg::ONE_Q14)) begin
            n_drive = vpid_pkg::ONE_Q14;
        end else if (scaled < (vpid_pkg::ACC_W-FRAC_SH_L)'(vpid_pkg::M_ONE_Q14)) begin
            n_drive = vpid_pkg::M_ONE_Q14;
        end else begin
            n_drive = scaled[vpid_pkg::VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_prod) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_tzero  <= i_word.tzero;
        end
        if (i_load_drive) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

### rtl/core/vpid_out.sv
// Output stage: holds the drive level and its millivolt equivalent out of
// 12 V, truncated toward zero. Uses vpid_pkg.
`timescale 1ns / 1ps

module vpid_out (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [vpid_pkg::VEL_W-1:0]     i_drive,
    output logic signed [vpid_pkg::VEL_W-1:0]     o_drive,
    output logic signed [vpid_pkg::MV_W-1:0]      o_mv
);

    localparam int PROD_W = vpid_pkg::VEL_W + vpid_pkg::MV_W;

    logic signed [vpid_pkg::VEL_W-1:0] r_drive;
    logic signed [vpid_pkg::MV_W-1:0]  r_mv, n_mv;
    logic signed [PROD_W-1:0]          prod, biased;

    always_comb begin
        prod = PROD_W'(i_drive) * PROD_W'(vpid_pkg::FULL_MV);
        // Bias negative values so the shift truncates toward zero.
        biased = prod[PROD_W-1]
               ? prod + PROD_W'((1 << vpid_pkg::MV_SH) - 1)
               : prod;
        n_mv = biased[vpid_pkg::MV_SH +: vpid_pkg::MV_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= i_drive;
            r_mv    <= n_mv;
        end
    end

    assign o_drive = r_drive;
    assign o_mv    = r_mv;

endmodule

### rtl/core/velocity_pid_with_windup_reset_core.sv
// Top level of the velocity PID core: configuration registers, input
// register, stage valids and the stream handshakes.
// Depends on vpid_pkg, vpid_err, vpid_mac, vpid_out and the macro header.
`timescale 1ns / 1ps
`include "velocity_pid_with_windup_reset_core_macros.svh"

// Usage
// Each word on the s_axis channel is one control tick carrying the measured
// velocity in Q2.14. Each tick gives exactly one word on m_axis: the clamped
// drive level in Q2.14 and the same drive in millivolts out of 12 V.
// Target, the three Q8.16 gains and the error limit must be written through
// the cfg port while no tick is in flight; the block does not enforce this.
// Timing: five register stages (input, error and integral, gain products,
// drive, output). One word can be accepted every cycle as long as
// m_axis_tready does not hold the pipeline back. The rate is set by the
// integral update, which closes inside the error stage.
// Every stage moves forward whenever the stage after it is empty or moving,
// so s_axis_tready stays high while bubbles remain; when m_axis_tready is
// held low the pipeline fills and s_axis_tready falls after five words.
// Reset (synchronous, active low) empties the pipeline, zeroes the integral
// and previous error, and loads target 0, gains 0 and error limit 65535.

module velocity_pid_with_windup_reset_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [15:0] measured_velocity
    // Output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [15:0] drive_level,
                                                             // [30:16] drive_millivolts
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [vpid_pkg::CFG_W-1:0]        i_cfg_data
);

    logic signed [vpid_pkg::VEL_W-1:0]  r_target;
    logic        [vpid_pkg::GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic signed [vpid_pkg::LIM_W-1:0]  r_err_limit;

    logic signed [vpid_pkg::VEL_W-1:0]  r_meas;
    logic                               r_v0, r_v1, r_v2, r_v3, r_v4;
    logic                               rdy0, rdy1, rdy2, rdy3, rdy4;

    vpid_pkg::t_err_word                err_word;
    logic signed [vpid_pkg::VEL_W-1:0]  drive_mid, drive_out;
    logic signed [vpid_pkg::MV_W-1:0]   mv_out;

    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign s_axis_tready = rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_err_limit <= vpid_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vpid_pkg::CFG_TARGET: r_target    <= i_cfg_data[vpid_pkg::VEL_W-1:0];
                vpid_pkg::CFG_KP:     r_kp        <= i_cfg_data[vpid_pkg::GAIN_W-1:0];
                vpid_pkg::CFG_KI:     r_ki        <= i_cfg_data[vpid_pkg::GAIN_W-1:0];
                vpid_pkg::CFG_KD:     r_kd        <= i_cfg_data[vpid_pkg::GAIN_W-1:0];
                vpid_pkg::CFG_LIMIT:  r_err_limit <= i_cfg_data[vpid_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= s_axis_tvalid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && s_axis_tvalid) begin
            r_meas <= s_axis_tdata[vpid_pkg::VEL_W-1:0];
        end
    end

    vpid_err u_err (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_v0 && rdy1),
        .i_meas      (r_meas),
        .i_target    (r_target),
        .i_err_limit (r_err_limit),
        .o_word      (err_word)
    );

    vpid_mac u_mac (
        .i_clk        (i_clk),
        .i_load_prod  (r_v1 && rdy2),
        .i_load_drive (r_v2 && rdy3),
        .i_word       (err_word),
        .i_kp         (r_kp),
        .i_ki         (r_ki),
        .i_kd         (r_kd),
        .o_drive      (drive_mid)
    );

    vpid_out u_out (
        .i_clk   (i_clk),
        .i_load  (r_v3 && rdy4),
        .i_drive (drive_mid),
        .o_drive (drive_out),
        .o_mv    (mv_out)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {1'b0, mv_out, drive_out};

    // The drive never leaves plus or minus one.
    `VPID_ASSERT(a_drive_range, i_clk, i_rst_n,
        m_axis_tvalid |-> (drive_out <= vpid_pkg::ONE_Q14 && drive_out >= vpid_pkg::M_ONE_Q14))
    // A zero target gives an all-zero result word.
    `VPID_ASSERT(a_zero_target, i_clk, i_rst_n,
        (m_axis_tvalid && r_target == '0) |-> (m_axis_tdata == '0))
    // The input side only stalls when every stage is full and the sink stalls.
    `VPID_ASSERT(a_stall_full, i_clk, i_rst_n,
        !s_axis_tready |-> (r_v0 && r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready))
    // Reset leaves no result word behind.
    `VPID_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !m_axis_tvalid)

endmodule

### bench/testbench.sv
// Self-checking bench for the velocity PID core: drives control ticks and
// register writes, predicts every drive word and checks it on the output.
// Depends on vpid_pkg and velocity_pid_with_windup_reset_core.
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_GAP       = 19;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_CAP    = 60;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 200;
    localparam int RUN_TICKS     = 60;
    localparam longint SUM_HI    = 64'sd2147483647;
    localparam longint SUM_LO    = -64'sd2147483648;

    typedef struct packed {
        logic signed [15:0] level;
        logic signed [14:0] millivolts;
    } t_drive_word;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [15:0]                s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [31:0]                m_axis_tdata;
    logic                       i_cfg_we      = 1'b0;
    logic [2:0]                 i_cfg_index   = '0;
    logic [vpid_pkg::CFG_W-1:0] i_cfg_data    = '0;

    // Bench copy of the block's registers and state.
    logic signed [15:0] tgt_reg  = '0;
    logic [23:0]        kp_reg   = '0;
    logic [23:0]        ki_reg   = '0;
    logic [23:0]        kd_reg   = '0;
    logic signed [16:0] lim_reg  = vpid_pkg::LIMIT_RST;
    longint             integ    = 0;
    longint             prev_err = 0;

    t_drive_word pending_drive[$];
    int          mismatches = 0;
    bit          idle_on    = 1'b1;

    velocity_pid_with_windup_reset_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint clamped_target();
        return clip(longint'(tgt_reg), -longint'(vpid_pkg::ONE_Q14),
                    longint'(vpid_pkg::ONE_Q14));
    endfunction

    // One control tick: updates the integral and previous error and returns
    // the drive word that the block should produce.
    function automatic t_drive_word predict_drive(input logic signed [15:0] meas_in);
        longint      tgt;
        longint      meas;
        longint      err;
        longint      deriv;
        longint      acc;
        longint      drive;
        longint      mv;
        t_drive_word w;
        tgt   = clamped_target();
        meas  = meas_in;
        err   = tgt - meas;
        integ = clip(integ + err, SUM_LO, SUM_HI);
        if (err == 0 || (meas < 0 ? -meas : meas) > (tgt < 0 ? -tgt : tgt)
                || err > longint'(lim_reg)) begin
            integ = 0;
        end
        deriv    = err - prev_err;
        prev_err = err;
        acc = longint'(kp_reg) * err + longint'(ki_reg) * integ
            + longint'(kd_reg) * deriv;
        // An arithmetic shift of a signed value rounds toward minus infinity.
        drive = clip(acc >>> vpid_pkg::FRAC_SH, -longint'(vpid_pkg::ONE_Q14),
                     longint'(vpid_pkg::ONE_Q14));
        if (tgt == 0) begin
            drive = 0;
        end
        mv           = (drive * vpid_pkg::FULL_MV) / longint'(vpid_pkg::ONE_Q14);
        w.level      = drive[15:0];
        w.millivolts = mv[14:0];
        return w;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx,
                                      input logic [vpid_pkg::CFG_W-1:0] val);
        case (idx)
            vpid_pkg::CFG_TARGET: tgt_reg = val[15:0];
            vpid_pkg::CFG_KP:     kp_reg  = val[23:0];
            vpid_pkg::CFG_KI:     ki_reg  = val[23:0];
            vpid_pkg::CFG_KD:     kd_reg  = val[23:0];
            vpid_pkg::CFG_LIMIT:  lim_reg = val[16:0];
            default: ;
        endcase
    endfunction

    task automatic send_tick(input logic [15:0] meas);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= meas;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_drive.push_back(predict_drive(meas));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write enable is left high so that back-to-back writes need no gap.
    task automatic write_reg(input logic [2:0] idx, input logic [vpid_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input int tgt, input int kp, input int ki, input int kd,
                               input int lim);
        drain();
        write_reg(vpid_pkg::CFG_TARGET, vpid_pkg::CFG_W'(tgt));
        write_reg(vpid_pkg::CFG_KP, vpid_pkg::CFG_W'(kp));
        write_reg(vpid_pkg::CFG_KI, vpid_pkg::CFG_W'(ki));
        write_reg(vpid_pkg::CFG_KD, vpid_pkg::CFG_W'(kd));
        write_reg(vpid_pkg::CFG_LIMIT, vpid_pkg::CFG_W'(lim));
        end_writes();
    endtask

    task automatic test_reset_state();
        send_tick(16'sd0);
        send_tick(16'sh7FFF);
        send_tick(16'sh8000);
    endtask

    task automatic test_error_paths();
        load_config(16384, 'h010000, 'h000100, 'h008000, 65535);
        send_tick(16'sd16384);   // zero error clears the integral
        send_tick(16'sd0);
        send_tick(-16'sd16384);
        send_tick(16'sh8000);    // measured magnitude above the target
        send_tick(16'sh7FFF);
        send_tick(16'sd8192);
        send_tick(16'sd8192);
    endtask

    task automatic test_gain_extremes();
        load_config(-16384, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 65535);
        send_tick(-16'sd16384);
        send_tick(16'sd16384);
        send_tick(16'sh8000);
        send_tick(16'sd0);
    endtask

    task automatic test_error_limit();
        load_config(8192, 'h010000, 'h001000, 0, -65536);
        send_tick(16'sd0);
        send_tick(16'sd4096);
        load_config(8192, 'h010000, 'h001000, 0, 0);
        send_tick(-16'sd4096);
        send_tick(16'sd4096);
    endtask

    task automatic test_target_clamp();
        load_config(32767, 'h020000, 'h000800, 'h004000, 65535);
        send_tick(16'sd1000);
        send_tick(16'sd1000);
        load_config(-32768, 'h020000, 'h000800, 'h004000, 65535);
        send_tick(-16'sd1000);
        // Bits above each register's width must be dropped.
        load_config('hA52000, 'h010000, 'h000800, 'h004000, 'hFF0001);
        send_tick(16'sd2000);
        send_tick(-16'sd2000);
    endtask

    task automatic test_unknown_index();
        drain();
        for (int k = int'(vpid_pkg::CFG_LIMIT) + 1; k < 8; k++) begin
            write_reg(3'(k), '1);
        end
        end_writes();
        send_tick(16'sd3000);
        send_tick(16'sd3000);
    endtask

    task automatic test_zero_target();
        load_config(0, 'h010000, 'h010000, 'h010000, 65535);
        send_tick(16'sd1000);
        send_tick(-16'sd1000);
        load_config(4096, 'h010000, 'h010000, 'h010000, 65535);
        send_tick(16'sd2000);
    endtask

    // Back-to-back runs of the largest error that keeps the integral alive,
    // first building it up and then driving it the other way.
    task automatic test_integral_runs();
        idle_on = 1'b0;
        load_config(16384, 0, 1, 0, 65535);
        repeat (RUN_TICKS) send_tick(-16'sd16384);
        load_config(-16384, 0, 1, 0, 65535);
        repeat (RUN_TICKS) send_tick(16'sd16384);
        idle_on = 1'b1;
    endtask

    task automatic test_random_ticks();
        int tgt;
        int kp;
        int ki;
        int kd;
        int lim;
        int tc;
        int span;
        int m;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    tgt = 16384; kp = 'hFFFFFF; ki = 'hFFFFFF; kd = 'hFFFFFF; lim = 65535;
                end
                1: begin
                    tgt = -16384; kp = 0; ki = 0; kd = 0; lim = -65536;
                end
                default: begin
                    tgt = $urandom;
                    kp  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 'h3FFFF);
                    ki  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 'h3FF);
                    kd  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 'h3FFFF);
                    lim = $urandom;
                end
            endcase
            load_config(tgt, kp, ki, kd, lim);
            idle_on = (phase != 3);
            tc = int'(clamped_target());
            repeat (PHASE_TICKS) begin
                span = 1 << $urandom_range(0, 11);
                case ($urandom_range(0, 7))
                    0, 1: m = $urandom_range(0, 65535);
                    2:    m = tc + $urandom_range(0, 2 * span) - span;
                    // Mostly stay between zero and the target so that the
                    // integral builds up instead of being cleared.
                    default: m = (tc >= 0) ? tc - $urandom_range(0, span)
                                           : tc + $urandom_range(0, span);
                endcase
                send_tick(16'(m));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin : drive_checker
        t_drive_word want;
        int          stall;
        wait (i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (pending_drive.size() == 0) begin
                if (mismatches < REPORT_CAP) $error("unexpected word %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                if (m_axis_tdata[15:0] !== want.level) begin
                    if (mismatches < REPORT_CAP) begin
                        $error("drive_level: expected %0d, actual %0d",
                               want.level, $signed(m_axis_tdata[15:0]));
                    end
                    mismatches++;
                end
                if (m_axis_tdata[30:16] !== want.millivolts) begin
                    if (mismatches < REPORT_CAP) begin
                        $error("drive_millivolts: expected %0d, actual %0d",
                               want.millivolts, $signed(m_axis_tdata[30:16]));
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_error_paths();
        test_gain_extremes();
        test_error_limit();
        test_target_clamp();
        test_unknown_index();
        test_zero_target();
        test_integral_runs();
        test_random_ticks();
        drain();
        if (mismatches == 0 && pending_drive.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
